// ===== sv/tiled_texture_address_macros.svh =====
// ----------------------------------------------------------------------------
// tiled_texture_address_macros
// Assertion macros for the tiled texture address generator.
// ----------------------------------------------------------------------------
`ifndef TILED_TEXTURE_ADDRESS_MACROS_SVH
`define TILED_TEXTURE_ADDRESS_MACROS_SVH

`ifndef SYNTHESIS

`define TTA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tiled_texture_address: assertion failed");

`define TTA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tiled_texture_address: assertion failed");

`else

`define TTA_ASSERT(lbl, prop)

`define TTA_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== sv/tta_pkg.sv =====
// ----------------------------------------------------------------------------
// tta_pkg
// Widths, register indexes and shared types of the tiled texture address
// generator.
// ----------------------------------------------------------------------------
package tta_pkg;

	localparam int OFFSET_W = 26;
	localparam int COL_W    = 13;
	localparam int ROW_W    = 14;
	localparam int CFG_W    = 14;
	localparam int LOG_W    = 3;
	localparam int CFG_IDX_W = 1;

	// macro-tile index width and divider split
	localparam int OM_W       = 16;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = OM_W / DIV_STEPS;

	localparam int MAX_WIDTH_BLOCKS_DEF = 8192;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXEL = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 14'd32;
	localparam logic [LOG_W-1:0] LOG_RESET   = 3'd2;
	localparam logic [LOG_W-1:0] LOG_MAX     = 3'd4;

	// low fields of the result, carried alongside the divider
	typedef struct packed {
		logic [1:0] tx;
		logic [2:0] microx;
		logic [1:0] ty;
		logic [2:0] ylow;
	} tta_side_t;

endpackage

// ===== sv/tta_if.sv =====
// ----------------------------------------------------------------------------
// tta_if
// Request and result channels of the tiled texture address generator.
// ----------------------------------------------------------------------------
interface tta_req_if import tta_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] block_offset;

	modport source (output valid, output block_offset, input ready);
	modport sink (input valid, input block_offset, output ready);
endinterface

interface tta_res_if import tta_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;

	modport source (output valid, output col, output row, input ready);
	modport sink (input valid, input col, input row, output ready);
endinterface

// ===== sv/tta_front.sv =====
// ----------------------------------------------------------------------------
// tta_front
// First stage: bit shuffle of the block offset into the macro-tile index
// and the low column and row fields.
// ----------------------------------------------------------------------------
module tta_front import tta_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OFFSET_W-1:0] block_offset,
	input  logic [LOG_W-1:0]    lg,
	output logic                valid_s1,
	input  logic                out_ready,
	output logic [OM_W-1:0]     om_s1,
	output tta_side_t           side_s1
);

	localparam int OB_W = OFFSET_W + 4;
	localparam int OT_W = OB_W - 3;

	logic [OB_W-1:0] ob;
	logic [OT_W-1:0] ot;
	logic [OT_W-1:0] om_sh;
	logic [OT_W-1:0] t_sh;
	logic            tbit;
	logic [6:0]      v7;
	logic [6:0]      v_sh;
	logic [10:0]     ymask;
	logic [9:0]      u;
	logic [9:0]      u_sh;
	logic [OM_W-1:0] om;
	tta_side_t       side;

	always_comb begin
		ob    = OB_W'(block_offset) << lg;
		ot    = {ob[OB_W-1:12], ob[10:8], ob[5:0]};
		om_sh = ot >> ({1'b0, lg} + 4'd7);
		om    = om_sh[OM_W-1:0];
		t_sh  = ot >> ({1'b0, lg} + 4'd6);
		tbit  = t_sh[0];
		v7    = {ot[7:5], ot[3:0]};
		v_sh  = v7 >> lg;
		ymask = ((11'd64 << lg) - 11'd1) & ~11'd31;
		u     = (ot[9:0] & ymask[9:0]) | {5'b0, ot[3:0], 1'b0};
		u_sh  = u >> ({1'b0, lg} + 4'd3);
		side.tx     = {tbit, 1'b0} + ob[7:6];
		side.microx = v_sh[2:0];
		side.ty     = {ob[11], tbit};
		side.ylow   = {u_sh[2:1], ot[4]};
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			om_s1   <= om;
			side_s1 <= side;
		end
	end

endmodule

// ===== sv/tta_div_stage.sv =====
// ----------------------------------------------------------------------------
// tta_div_stage
// One stage of the restoring divider: STEPS quotient bits per stage,
// remainder and quotient shift together, the quotient's top bit entering the remainder.
// ----------------------------------------------------------------------------
module tta_div_stage import tta_pkg::*; #(
	parameter int DW    = 9,
	parameter int STEPS = DIV_STEPS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [DW-1:0]   divisor,
	input  logic [DW-1:0]   rem_in,
	input  logic [OM_W-1:0] nq_in,
	input  tta_side_t       side_in,
	output logic            valid_s,
	input  logic            out_ready,
	output logic [DW-1:0]   rem_s,
	output logic [OM_W-1:0] nq_s,
	output tta_side_t       side_s
);

	logic [DW-1:0]   r;
	logic [OM_W-1:0] n;
	logic [DW:0]     t;

	always_comb begin
		r = rem_in;
		n = nq_in;
		t = '0;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, n[OM_W-1]};
			n = n << 1;
			if (t >= {1'b0, divisor}) begin
				t    = t - {1'b0, divisor};
				n[0] = 1'b1;
			end
			r = t[DW-1:0];
		end
	end

	assign in_ready = !valid_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_s  <= r;
			nq_s   <= n;
			side_s <= side_in;
		end
	end

endmodule

// ===== sv/tiled_texture_address.sv =====
// ----------------------------------------------------------------------------
// tiled_texture_address
// Detiling address generator: linear block offset of a 2D tiled surface in,
// block column and row out.
//
//   channel  dir  payload
//   req      in   block_offset[25:0]
//   res      out  col[12:0], row[13:0]
//   cfg      in   cfg_we, cfg_idx, cfg_wdata[13:0] (write only)
//
// One request per cycle unless held by backpressure; the front stage feeds the DIV_STAGES
// stages of the pipelined divider splitting the macro-tile index by the row pitch.
// Each stage holds under backpressure and fills bubbles independently.
// arst_n clears valid bits and loads width 32, 4-byte blocks.
// ----------------------------------------------------------------------------
module tiled_texture_address import tta_pkg::*; #(
	parameter int MAX_WIDTH_BLOCKS = MAX_WIDTH_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tta_req_if.sink              req,
	tta_res_if.source            res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	`include "tiled_texture_address_macros.svh"

	localparam int MPR_MAX = MAX_WIDTH_BLOCKS / 32;
	localparam int DW      = $clog2(MPR_MAX + 1);
	localparam int WC_W    = CFG_W + 1;

	// macro tiles per row from a raw width
	function automatic logic [DW-1:0] mpr_of(input logic [CFG_W-1:0] w);
		logic [WC_W-1:0] wc;
		logic [WC_W-1:0] sum;
		wc = {1'b0, w};
		if (wc == '0) begin
			wc = WC_W'(1);
		end
		if (wc > WC_W'(MAX_WIDTH_BLOCKS)) begin
			wc = WC_W'(MAX_WIDTH_BLOCKS);
		end
		sum = wc + WC_W'(31);
		return DW'(sum >> 5);
	endfunction

	logic [DW-1:0]    mpr_q;
	logic [LOG_W-1:0] lg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpr_q <= mpr_of(WIDTH_RESET);
			lg_q  <= LOG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH: begin
					mpr_q <= mpr_of(cfg_wdata);
				end
				REG_TEXEL: begin
					lg_q <= (cfg_wdata[LOG_W-1:0] > LOG_MAX) ? LOG_MAX
						: cfg_wdata[LOG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic            valid_w [0:DIV_STAGES];
	logic            ready_w [0:DIV_STAGES];
	logic [DW-1:0]   rem_w   [0:DIV_STAGES];
	logic [OM_W-1:0] nq_w    [0:DIV_STAGES];
	tta_side_t       side_w  [0:DIV_STAGES];

	tta_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.block_offset (req.block_offset),
		.lg           (lg_q),
		.valid_s1     (valid_w[0]),
		.out_ready    (ready_w[0]),
		.om_s1        (nq_w[0]),
		.side_s1      (side_w[0])
	);

	assign rem_w[0] = '0;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		tta_div_stage #(
			.DW    (DW),
			.STEPS (DIV_STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_w[g]),
			.in_ready  (ready_w[g]),
			.divisor   (mpr_q),
			.rem_in    (rem_w[g]),
			.nq_in     (nq_w[g]),
			.side_in   (side_w[g]),
			.valid_s   (valid_w[g+1]),
			.out_ready (ready_w[g+1]),
			.rem_s     (rem_w[g+1]),
			.nq_s      (nq_w[g+1]),
			.side_s    (side_w[g+1])
		);
	end

	assign ready_w[DIV_STAGES] = res.ready;
	assign res.valid = valid_w[DIV_STAGES];
	assign res.col = COL_W'({rem_w[DIV_STAGES], side_w[DIV_STAGES].tx,
		side_w[DIV_STAGES].microx});
	assign res.row = ROW_W'({nq_w[DIV_STAGES], side_w[DIV_STAGES].ty,
		side_w[DIV_STAGES].ylow});

	`TTA_ASSERT(a_mpr_nonzero, mpr_q != '0)
	`TTA_ASSERT_NEXT(a_width_zero, cfg_we && cfg_idx == REG_WIDTH && cfg_wdata == '0, mpr_q == DW'(1))
	`TTA_ASSERT_NEXT(a_log_sat, cfg_we && cfg_idx == REG_TEXEL && cfg_wdata[LOG_W-1:0] > LOG_MAX, lg_q == LOG_MAX)

endmodule
